// ----- rtl/assert_macros.svh -----
// Assertion helpers, sampled on clk, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/slp_pkg.sv -----
`default_nettype none

package slp_pkg;

    localparam int HANDLE_W           = 6;
    localparam int MODE_W             = 2;
    localparam int STATUS_W           = 2;
    localparam int TDATA_W            = 8;
    localparam int TUSER_W            = 2;
    localparam int DEFAULT_POOL_SLOTS = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_TRY   = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NONE_FREE = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/slot_pool_allocator.sv -----
// A request is accepted in S_IDLE and executed in S_EXEC; the result is registered into
// the output register on leaving S_EXEC. The queue and bitmap RAMs are read on
// acceptance and written back in the following cycle, one request in flight.
// Reset (rst_n, async, active low): free queue empty, no slot allocated, no result
// pending. No clearing pass: bitmap entries at or above the fresh pointer read as free.
`default_nettype none
`include "assert_macros.svh"

module slot_pool_allocator
    import slp_pkg::*;
#(
    parameter int POOL_SLOTS = DEFAULT_POOL_SLOTS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [TDATA_W-1:0] s_axis_tdata,   // [5:0] handle
    input  wire logic [TUSER_W-1:0] s_axis_tuser,   // [1:0] mode
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic      [TDATA_W-1:0] m_axis_tdata,   // [5:0] granted_handle
    output logic      [TUSER_W-1:0] m_axis_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(POOL_SLOTS);
    localparam int CNT_W = $clog2(POOL_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);
    localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SLOTS);

    state_t                state_reg, state_next;
    logic [MODE_W-1:0]     mode_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      fresh_reg, fresh_next;
    logic                  out_valid_reg, out_valid_next;
    logic [HANDLE_W-1:0]   grant_reg, grant_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    logic                  in_fire;
    logic                  q_we;
    logic [HANDLE_W-1:0]   q_rdata;
    logic                  bm_we;
    logic [IDX_W-1:0]      bm_waddr;
    logic                  bm_wdata;
    logic                  bm_rdata;
    logic                  handle_in_pool;
    logic                  handle_alloc;

    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // free queue
    slp_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (POOL_SLOTS)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (handle_reg),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    // allocated bitmap
    slp_ram #(
        .WIDTH (1),
        .DEPTH (POOL_SLOTS)
    ) u_map_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (IDX_W'(s_axis_tdata[HANDLE_W-1:0])),
        .rdata (bm_rdata)
    );

    assign handle_in_pool = 32'(handle_reg) < POOL_SLOTS;
    // entries at or above the fresh pointer have never been written
    assign handle_alloc   = bm_rdata && (32'(handle_reg) < 32'(fresh_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg   <= s_axis_tuser[MODE_W-1:0];
            handle_reg <= s_axis_tdata[HANDLE_W-1:0];
        end
        grant_reg  <= grant_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        grant_next     = grant_reg;
        status_next    = status_reg;
        q_we           = 1'b0;
        bm_we          = 1'b0;
        bm_waddr       = IDX_W'(q_rdata);
        bm_wdata       = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                grant_next     = '0;
                status_next    = ST_OK;
                case (mode_reg)
                    MODE_ALLOC, MODE_TRY:
                    begin
                        if (count_reg != '0)
                        begin
                            grant_next = q_rdata;
                            bm_we      = 1'b1;
                            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
                            count_next = count_reg - CNT_W'(1);
                        end
                        else if (mode_reg == MODE_TRY)
                        begin
                            status_next = ST_NONE_FREE;
                        end
                        else if (fresh_reg < POOL_CNT)
                        begin
                            grant_next = HANDLE_W'(fresh_reg);
                            bm_we      = 1'b1;
                            bm_waddr   = IDX_W'(fresh_reg);
                            fresh_next = fresh_reg + CNT_W'(1);
                        end
                        else
                        begin
                            status_next = ST_EXHAUSTED;
                        end
                    end
                    MODE_FREE:
                    begin
                        if (!handle_in_pool || !handle_alloc || count_reg >= POOL_CNT)
                        begin
                            status_next = ST_NOT_ALLOC;
                        end
                        else
                        begin
                            bm_we      = 1'b1;
                            bm_waddr   = IDX_W'(handle_reg);
                            bm_wdata   = 1'b0;
                            q_we       = 1'b1;
                            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(grant_reg);
    assign m_axis_tuser  = TUSER_W'(status_reg);

    `ASSERT_NXT(a_fire_to_exec, in_fire, state_reg == S_EXEC)
    `ASSERT_IMP(a_exec_out_free, state_reg == S_EXEC, !out_valid_reg)
    `ASSERT_NXT(a_exec_gives_result, state_reg == S_EXEC, out_valid_reg)
    `ASSERT_IMP(a_count_bound, 1'b1, count_reg <= POOL_CNT && fresh_reg <= POOL_CNT)
    `ASSERT_IMP(a_reject_no_grant, out_valid_reg && status_reg != ST_OK, grant_reg == '0)

endmodule

`default_nettype wire

// ----- rtl/slp_ram.sv -----
`default_nettype none

module slp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
